// ----- rtl/ndr_pkg.sv -----
// Shared types and constants for the NTFS data-run decoder.
package ndr_pkg;

  localparam int unsigned ByteW         = 8;
  localparam int unsigned NibW          = 4;
  localparam int unsigned WordW         = 64;
  localparam int unsigned IdxW          = 4;
  localparam int unsigned TotW          = IdxW + 1;
  // Largest legal byte count of a length or offset field.
  localparam int unsigned MaxFieldBytes = 8;
  // Bytes in a full-width offset; such an offset needs no sign extension.
  localparam int unsigned WordBytes     = WordW / ByteW;

  // Header byte that terminates a run list.
  localparam logic [ByteW-1:0] HdrEnd = 8'h00;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_HEADER = 2'd1,
    PH_GATHER = 2'd2
  } phase_e;

  typedef struct packed {
    logic [WordW-1:0]        run_len;
    logic signed [WordW-1:0] run_start_cluster;
    logic                    no_offset_run;
    logic                    list_end;
    logic                    bad_header;
  } result_t;

endpackage

// ----- rtl/ndr_decode.sv -----
// Run-list parse state, field accumulators and running cluster update.
module ndr_decode (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic [ndr_pkg::ByteW-1:0]  data_byte_i,
  input  logic                       list_start_i,
  output logic                       res_valid_o,
  output ndr_pkg::result_t           res_o
);

  ndr_pkg::phase_e                   phase_q, phase_d;
  logic [ndr_pkg::IdxW-1:0]          idx_q, idx_d;
  logic [ndr_pkg::NibW-1:0]          lb_q, lb_d;
  logic [ndr_pkg::NibW-1:0]          ob_q, ob_d;
  logic [ndr_pkg::WordW-1:0]         len_acc_q, len_acc_d;
  logic [ndr_pkg::WordW-1:0]         off_acc_q, off_acc_d;
  logic [ndr_pkg::WordW-1:0]         cluster_q, cluster_d;

  logic [ndr_pkg::NibW-1:0]          hdr_lb, hdr_ob;
  logic                              hdr_zero, hdr_bad;
  logic                              take_hdr, take_fld;
  logic [ndr_pkg::TotW-1:0]          total;
  logic                              last;
  logic                              in_len;
  logic [ndr_pkg::IdxW-1:0]          off_pos;
  logic [ndr_pkg::NibW-1:0]          ob_m1;
  logic [ndr_pkg::WordW-1:0]         byte_ext;
  logic [ndr_pkg::WordW-1:0]         len_new, off_new;
  logic [ndr_pkg::WordW-1:0]         keep_mask, off_ext;
  logic                              sign_bit, ext_en;
  logic [ndr_pkg::WordW-1:0]         sum;

  assign hdr_lb   = data_byte_i[ndr_pkg::NibW-1:0];
  assign hdr_ob   = data_byte_i[ndr_pkg::ByteW-1:ndr_pkg::NibW];
  assign hdr_zero = (data_byte_i == ndr_pkg::HdrEnd);
  assign hdr_bad  = (hdr_lb > ndr_pkg::NibW'(ndr_pkg::MaxFieldBytes)) ||
                    (hdr_ob > ndr_pkg::NibW'(ndr_pkg::MaxFieldBytes));

  assign take_hdr = list_start_i || (phase_q == ndr_pkg::PH_HEADER);
  assign take_fld = !list_start_i && (phase_q == ndr_pkg::PH_GATHER);

  assign total   = {1'b0, lb_q} + {1'b0, ob_q};
  assign last    = ({1'b0, idx_q} + ndr_pkg::TotW'(1)) >= total;
  assign in_len  = ({1'b0, idx_q} < {1'b0, lb_q});
  assign off_pos = idx_q - lb_q;

  // Merge the incoming byte at its little-endian lane.
  assign byte_ext = ndr_pkg::WordW'(data_byte_i);
  assign len_new  = in_len ? (len_acc_q | (byte_ext << {idx_q[2:0], 3'b000})) : len_acc_q;
  assign off_new  = in_len ? off_acc_q : (off_acc_q | (byte_ext << {off_pos[2:0], 3'b000}));

  // Sign-extend a short offset from the top bit of its last byte.
  assign ob_m1     = ob_q - ndr_pkg::NibW'(1);
  assign sign_bit  = off_new[{ob_m1[2:0], 3'b111}];
  assign keep_mask = (ndr_pkg::WordW'(1) << {ob_q[2:0], 3'b000}) - ndr_pkg::WordW'(1);
  assign ext_en    = (ob_q != '0) && (ob_q < ndr_pkg::NibW'(ndr_pkg::WordBytes));
  assign off_ext   = (ext_en && sign_bit) ? (off_new | ~keep_mask) : off_new;
  assign sum       = cluster_q + off_ext;

  // Next phase.
  always_comb begin
    phase_d = phase_q;
    if (en_i) begin
      if (take_hdr) begin
        phase_d = (hdr_zero || hdr_bad) ? ndr_pkg::PH_IDLE : ndr_pkg::PH_GATHER;
      end else if (take_fld && last) begin
        phase_d = ndr_pkg::PH_HEADER;
      end
    end
  end

  // Datapath updates.
  always_comb begin
    idx_d     = idx_q;
    lb_d      = lb_q;
    ob_d      = ob_q;
    len_acc_d = len_acc_q;
    off_acc_d = off_acc_q;
    cluster_d = cluster_q;
    if (en_i) begin
      if (list_start_i) begin
        cluster_d = '0;
      end
      if (take_hdr && !hdr_zero && !hdr_bad) begin
        lb_d      = hdr_lb;
        ob_d      = hdr_ob;
        idx_d     = '0;
        len_acc_d = '0;
        off_acc_d = '0;
      end
      if (take_fld) begin
        len_acc_d = len_new;
        off_acc_d = off_new;
        idx_d     = last ? '0 : idx_q + ndr_pkg::IdxW'(1);
        if (last) begin
          cluster_d = sum;
        end
      end
    end
  end

  // Result of the current transaction.
  always_comb begin
    res_valid_o             = (take_hdr && (hdr_zero || hdr_bad)) || (take_fld && last);
    res_o.run_len           = take_fld ? len_new : '0;
    res_o.run_start_cluster = take_fld ? sum : '0;
    res_o.no_offset_run     = take_fld && (ob_q == '0);
    res_o.list_end          = take_hdr && hdr_zero;
    res_o.bad_header        = take_hdr && !hdr_zero && hdr_bad;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= ndr_pkg::PH_IDLE;
      idx_q     <= '0;
      lb_q      <= '0;
      ob_q      <= '0;
      cluster_q <= '0;
    end else begin
      phase_q   <= phase_d;
      idx_q     <= idx_d;
      lb_q      <= lb_d;
      ob_q      <= ob_d;
      cluster_q <= cluster_d;
    end
  end

  always_ff @(posedge clk_i) begin
    len_acc_q <= len_acc_d;
    off_acc_q <= off_acc_d;
  end

  // Field index stays inside the run announced by the header.
  a_idx_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == ndr_pkg::PH_GATHER) |-> ({1'b0, idx_q} < total))
    else $error("field index beyond header byte counts");

  // A list start never leaves the parser waiting for a header.
  a_start_hdr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_i && list_start_i) |=> (phase_q != ndr_pkg::PH_HEADER))
    else $error("list start did not consume a header");

  // A finished run always returns the parser to header phase.
  a_run_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_i && take_fld && last) |=> (phase_q == ndr_pkg::PH_HEADER && idx_q == '0))
    else $error("run completion did not rearm header");

endmodule

// ----- rtl/ntfs_data_run_decoder_unit.sv -----
// Top level of the NTFS data-run list decoder: input and result registers.
//
// Decodes an NTFS data-run list fed one byte per transaction. A byte with
// list_start_i high is a header that begins a new list and clears the running
// start cluster; later headers follow each run. Length and offset fields are
// gathered little-endian, the offset is sign-extended and added to the running
// cluster, and the last field byte of a run yields one result transaction with
// the run length and absolute start cluster (no_offset_run_o marks an empty
// offset field). A zero header yields a list_end_o result and the decoder goes
// idle; a header with a field count above eight yields a bad_header_o result
// and bytes are dropped until the next list start. Other header bytes and
// non-final field bytes produce no result. Throughput is one byte per clock
// while the output is not stalled: each byte is captured in an input register
// and decoded (a byte lane merge plus one 64-bit add) into the output register;
// a result appears there once its last byte has left the input register.
// Output backpressure stalls the input register and, through it, in_ready_o.
module ntfs_data_run_decoder_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [ndr_pkg::ByteW-1:0]         data_byte_i,
  input  logic                              list_start_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [ndr_pkg::WordW-1:0]         run_len_o,
  output logic signed [ndr_pkg::WordW-1:0]  run_start_cluster_o,
  output logic                              no_offset_run_o,
  output logic                              list_end_o,
  output logic                              bad_header_o
);

  // Input register.
  logic                      s1_valid_q, s1_valid_d;
  logic [ndr_pkg::ByteW-1:0] s1_byte_q;
  logic                      s1_start_q;
  logic                      s1_go;

  // Result register.
  logic                      out_valid_q, out_valid_d;
  ndr_pkg::result_t          out_q;

  logic                      res_valid;
  ndr_pkg::result_t          res;

  // The held byte moves on when the result register is free or draining.
  assign s1_go      = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_go;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_valid_i && in_ready_o) begin
      s1_valid_d = 1'b1;
    end else if (s1_go) begin
      s1_valid_d = 1'b0;
    end
  end

  ndr_decode u_decode (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (s1_go),
    .data_byte_i  (s1_byte_q),
    .list_start_i (s1_start_q),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_go) begin
      out_valid_d = res_valid;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers, no reset.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_byte_q  <= data_byte_i;
      s1_start_q <= list_start_i;
    end
    if (s1_go && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign run_len_o           = out_q.run_len;
  assign run_start_cluster_o = out_q.run_start_cluster;
  assign no_offset_run_o     = out_q.no_offset_run;
  assign list_end_o          = out_q.list_end;
  assign bad_header_o        = out_q.bad_header;

  // At most one kind of marker per result transaction.
  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> $onehot0({out_q.no_offset_run, out_q.list_end, out_q.bad_header}))
    else $error("conflicting result flags");

  // End and error markers carry zero run data.
  a_marker_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_q.list_end || out_q.bad_header)) |->
      (out_q.run_len == '0 && out_q.run_start_cluster == '0))
    else $error("marker result carries run data");

  // A stalled result is not overwritten.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !s1_go)
    else $error("result register overwritten while stalled");

endmodule
